// ===== rtl/voxel_raycast_observed_space_core_macros.svh =====
// assertion macros for the voxel ray-cast core checker
// no dependencies; taken in by the checker file
`ifndef VOXEL_RAYCAST_OBSERVED_SPACE_CORE_MACROS_SVH
`define VOXEL_RAYCAST_OBSERVED_SPACE_CORE_MACROS_SVH

// same-cycle implication
`define VRC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VRC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/vrc_pkg.sv =====
// shared types, codes and fixed widths of the voxel ray-cast core
// no dependencies
package vrc_pkg;

  // fixed datapath widths
  localparam int RW      = 18;  // ray length root and step count
  localparam int SUM_W   = 34;  // sum of squared deltas
  localparam int NUM_W   = 37;  // signed scaled numerator
  localparam int DEN_W   = 28;  // steps times voxel
  localparam int MUL_W   = 19;  // multiplier operand
  localparam int PROD_W  = 38;  // multiplier product
  localparam int STEP2_W = 15;  // step in half millimetres
  localparam int CNT_W   = 5;   // phase counter
  localparam int SETUP_LAST = 5;
  localparam int SQ_LAST    = 3;

  // item commands
  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_POINT = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  localparam logic [1:0] CMD_QUERY = 2'd3;

  // cell marks
  localparam logic [1:0] MARK_UNKNOWN = 2'd0;
  localparam logic [1:0] MARK_FREE    = 2'd1;
  localparam logic [1:0] MARK_OCC     = 2'd2;

  // query classes that do not come from a mark
  localparam logic [2:0] CLASS_NONE = 3'd0;
  localparam logic [2:0] CLASS_OFF  = 3'd4;

  // register indexes
  localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] CFG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] CFG_VOXEL    = 3'd3;
  localparam logic [2:0] CFG_STEP     = 3'd4;
  localparam logic [2:0] CFG_DECIM    = 3'd5;
  localparam logic [2:0] CFG_TRACK    = 3'd6;
  localparam logic [2:0] CFG_ACCUM    = 3'd7;

  // datapath operations issued by the controller
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE  = 4'd0;
  localparam op_t OP_TAKE  = 4'd1;
  localparam op_t OP_BEGIN = 4'd2;
  localparam op_t OP_END   = 4'd3;
  localparam op_t OP_SQ    = 4'd4;
  localparam op_t OP_ROOT  = 4'd5;
  localparam op_t OP_NDIV  = 4'd6;
  localparam op_t OP_SETUP = 4'd7;
  localparam op_t OP_SDIV  = 4'd8;
  localparam op_t OP_PDIV  = 4'd9;
  localparam op_t OP_MFREE = 4'd10;
  localparam op_t OP_SFREE = 4'd11;
  localparam op_t OP_MOCC  = 4'd12;
  localparam op_t OP_QRY   = 4'd13;
  localparam op_t OP_CLR   = 4'd14;
  localparam op_t OP_EMIT  = 4'd15;

  typedef struct packed {
    logic signed [15:0] ox;
    logic signed [15:0] oy;
    logic signed [15:0] oz;
    logic [9:0]         voxel;
    logic [13:0]        samp_step;
    logic [7:0]         decim;
    logic               track;
    logic               acc;
  } cfg_t;

  typedef struct packed {
    logic last;          // current multi-cycle op finishes this cycle
    logic cast;          // begin item starts a cast cloud
    logic acc;           // marks kept across clouds
    logic active;        // cast cloud open
    logic over;          // marked count above limit in a cast cloud
    logic samples_done;  // last ray sample being written
    logic out_free;      // output register can take a word
  } status_t;

endpackage

// ===== rtl/vrc_ctrl.sv =====
// controller state machine of the voxel ray-cast core
// depends on vrc_pkg
module vrc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic [1:0]       s_tuser,
  output logic             s_tready,
  input  vrc_pkg::status_t st,
  output vrc_pkg::op_t     op
);

  localparam logic [4:0] S_INIT  = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_BEGIN = 5'd2;
  localparam logic [4:0] S_EP    = 5'd3;
  localparam logic [4:0] S_END   = 5'd4;
  localparam logic [4:0] S_CLR   = 5'd5;
  localparam logic [4:0] S_SQ    = 5'd6;
  localparam logic [4:0] S_ROOT  = 5'd7;
  localparam logic [4:0] S_NDIV  = 5'd8;
  localparam logic [4:0] S_SETUP = 5'd9;
  localparam logic [4:0] S_SDIV  = 5'd10;
  localparam logic [4:0] S_SRD   = 5'd11;
  localparam logic [4:0] S_SWR   = 5'd12;
  localparam logic [4:0] S_PDIV  = 5'd13;
  localparam logic [4:0] S_PRD   = 5'd14;
  localparam logic [4:0] S_PWR   = 5'd15;
  localparam logic [4:0] S_DONE  = 5'd16;

  logic [4:0] state, state_next;
  logic [1:0] kind;

  // state register and item kind
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      kind <= s_tuser;
    end
  end

  // next state and datapath op
  always_comb begin
    state_next = state;
    op         = vrc_pkg::OP_NONE;
    s_tready   = 1'b0;
    case (state)
      S_INIT: begin
        op = vrc_pkg::OP_CLR;
        if (st.last) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          op = vrc_pkg::OP_TAKE;
          case (s_tuser)
            vrc_pkg::CMD_BEGIN: state_next = S_BEGIN;
            vrc_pkg::CMD_POINT: state_next = S_EP;
            vrc_pkg::CMD_END:   state_next = S_END;
            default:            state_next = S_PDIV;
          endcase
        end
      end
      S_BEGIN: begin
        op = vrc_pkg::OP_BEGIN;
        if (st.cast) state_next = st.acc ? S_PDIV : S_CLR;
        else         state_next = S_DONE;
      end
      S_EP: begin
        state_next = st.active ? S_SQ : S_DONE;
      end
      S_END: begin
        op = vrc_pkg::OP_END;
        state_next = st.over ? S_CLR : S_DONE;
      end
      S_CLR: begin
        op = vrc_pkg::OP_CLR;
        if (st.last) state_next = (kind == vrc_pkg::CMD_BEGIN) ? S_PDIV : S_DONE;
      end
      S_SQ: begin
        op = vrc_pkg::OP_SQ;
        if (st.last) state_next = S_ROOT;
      end
      S_ROOT: begin
        op = vrc_pkg::OP_ROOT;
        if (st.last) state_next = S_NDIV;
      end
      S_NDIV: begin
        op = vrc_pkg::OP_NDIV;
        if (st.last) state_next = S_SETUP;
      end
      S_SETUP: begin
        op = vrc_pkg::OP_SETUP;
        if (st.last) state_next = S_SDIV;
      end
      S_SDIV: begin
        op = vrc_pkg::OP_SDIV;
        if (st.last) state_next = S_SRD;
      end
      S_SRD: begin
        state_next = S_SWR;
      end
      S_SWR: begin
        op = vrc_pkg::OP_SFREE;
        state_next = st.samples_done ? S_PDIV : S_SDIV;
      end
      S_PDIV: begin
        op = vrc_pkg::OP_PDIV;
        if (st.last) state_next = S_PRD;
      end
      S_PRD: begin
        state_next = S_PWR;
      end
      S_PWR: begin
        case (kind)
          vrc_pkg::CMD_BEGIN: op = vrc_pkg::OP_MFREE;
          vrc_pkg::CMD_POINT: op = vrc_pkg::OP_MOCC;
          default:            op = vrc_pkg::OP_QRY;
        endcase
        state_next = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          op = vrc_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

// ===== rtl/vrc_datapath.sv =====
// datapath of the voxel ray-cast core: length, step count, cell divider, grid memory
// depends on vrc_pkg
module vrc_datapath #(
  parameter int GRID_X_BITS = 7,
  parameter int GRID_Y_BITS = 7,
  parameter int GRID_Z_BITS = 5,
  parameter int MARK_LIMIT  = 262144
) (
  input  logic              clk,
  input  logic              rst,
  input  vrc_pkg::cfg_t     cfg,
  input  vrc_pkg::op_t      op,
  input  logic [47:0]       in_data,
  output vrc_pkg::status_t  st,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata
);

  localparam int CELL_BITS = GRID_X_BITS + GRID_Y_BITS + GRID_Z_BITS;
  localparam int QB = (GRID_X_BITS > GRID_Y_BITS)
                      ? ((GRID_X_BITS > GRID_Z_BITS) ? GRID_X_BITS : GRID_Z_BITS)
                      : ((GRID_Y_BITS > GRID_Z_BITS) ? GRID_Y_BITS : GRID_Z_BITS);
  localparam int CMP_W = vrc_pkg::NUM_W + QB;
  localparam int DSH_W = vrc_pkg::DEN_W + QB - 1;
  localparam int MC_W  = CELL_BITS + 1;
  localparam int RW    = vrc_pkg::RW;
  localparam int NUM_W = vrc_pkg::NUM_W;
  localparam int AB [3] = '{GRID_X_BITS, GRID_Y_BITS, GRID_Z_BITS};

  // item, sensor and cloud state
  logic signed [15:0] pt [3];
  logic signed [15:0] sen [3];
  logic               active;
  logic [7:0]         phase;
  logic [MC_W-1:0]    mcount;

  // sequencing
  logic [vrc_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [CELL_BITS-1:0]      clr_cnt;
  logic                      last, multi;

  // arithmetic
  logic signed [16:0]                pdiff [3];
  logic signed [16:0]                dlt [3];
  logic signed [16:0]                esen [3];
  logic signed [vrc_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [vrc_pkg::PROD_W-1:0] prod;
  logic [vrc_pkg::SUM_W-1:0]         sum;
  logic [2*RW-1:0]                   rv;
  logic [RW+1:0]                     rrem;
  logic [RW+3:0]                     rcat;
  logic [RW+1:0]                     rtry;
  logic [RW-1:0]                     root;
  logic [vrc_pkg::STEP2_W-1:0]       step2, nrem;
  logic [vrc_pkg::STEP2_W:0]         ncat;
  logic [RW-1:0]                     nq, steps, s_idx;
  logic [vrc_pkg::DEN_W-1:0]         den, den_src;
  logic signed [NUM_W-1:0]           nacc [3];
  logic [NUM_W-1:0]                  lnum [3];
  logic [9:0]                        vox_eff;
  logic [7:0]                        dec_eff, phase_inc;
  logic                              cast, over;

  // cell divider lanes
  logic [DSH_W-1:0]   dsh;
  logic [NUM_W-2:0]   drem [3];
  logic [QB-1:0]      dq [3];
  logic               dok [3];
  logic               ok_all;
  logic [CELL_BITS-1:0] idx;

  // grid memory
  logic [1:0]           mem [2**CELL_BITS];
  logic [1:0]           rdata, wdata;
  logic [CELL_BITS-1:0] waddr;
  logic                 mem_we, cnt_up;

  // result
  logic [2:0] res_class;
  logic       res_taken, res_cleared;

  assign vox_eff   = (cfg.voxel == 10'd0) ? 10'd1 : cfg.voxel;
  assign dec_eff   = (cfg.decim == 8'd0) ? 8'd1 : cfg.decim;
  assign phase_inc = phase + 8'd1;
  assign cast      = cfg.track && (phase_inc >= dec_eff);
  assign over      = active && (32'(mcount) > 32'(MARK_LIMIT));
  assign step2     = ({cfg.samp_step, 1'b0} < {5'd0, vox_eff}) ? {5'd0, vox_eff}
                                                              : {cfg.samp_step, 1'b0};

  // per-axis deltas
  always_comb begin
    pdiff[0] = {pt[0][15], pt[0]} - {cfg.ox[15], cfg.ox};
    pdiff[1] = {pt[1][15], pt[1]} - {cfg.oy[15], cfg.oy};
    pdiff[2] = {pt[2][15], pt[2]} - {cfg.oz[15], cfg.oz};
    esen[0]  = {sen[0][15], sen[0]} - {cfg.ox[15], cfg.ox};
    esen[1]  = {sen[1][15], sen[1]} - {cfg.oy[15], cfg.oy};
    esen[2]  = {sen[2][15], sen[2]} - {cfg.oz[15], cfg.oz};
    for (int k = 0; k < 3; k++) begin
      dlt[k]  = {pt[k][15], pt[k]} - {sen[k][15], sen[k]};
      lnum[k] = (op == vrc_pkg::OP_PDIV) ? {{(NUM_W-17){pdiff[k][16]}}, pdiff[k]}
                                         : nacc[k];
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      vrc_pkg::OP_SQ: begin
        case (cnt)
          5'd0:    mul_a = {{2{dlt[0][16]}}, dlt[0]};
          5'd1:    mul_a = {{2{dlt[1][16]}}, dlt[1]};
          default: mul_a = {{2{dlt[2][16]}}, dlt[2]};
        endcase
        mul_b = mul_a;
      end
      vrc_pkg::OP_SETUP: begin
        mul_b = {1'b0, steps};
        case (cnt)
          5'd1:    mul_a = {9'd0, vox_eff};
          5'd2:    mul_a = {{2{esen[0][16]}}, esen[0]};
          5'd3:    mul_a = {{2{esen[1][16]}}, esen[1]};
          default: mul_a = {{2{esen[2][16]}}, esen[2]};
        endcase
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // phase ends and counter
  always_comb begin
    case (op)
      vrc_pkg::OP_SQ:    last = (cnt == vrc_pkg::CNT_W'(vrc_pkg::SQ_LAST));
      vrc_pkg::OP_ROOT:  last = (cnt == vrc_pkg::CNT_W'(RW));
      vrc_pkg::OP_NDIV:  last = (cnt == vrc_pkg::CNT_W'(RW));
      vrc_pkg::OP_SETUP: last = (cnt == vrc_pkg::CNT_W'(vrc_pkg::SETUP_LAST));
      vrc_pkg::OP_SDIV:  last = (cnt == vrc_pkg::CNT_W'(QB));
      vrc_pkg::OP_PDIV:  last = (cnt == vrc_pkg::CNT_W'(QB));
      vrc_pkg::OP_CLR:   last = &clr_cnt;
      default:           last = 1'b1;
    endcase
    multi = (op == vrc_pkg::OP_SQ) || (op == vrc_pkg::OP_ROOT) || (op == vrc_pkg::OP_NDIV)
         || (op == vrc_pkg::OP_SETUP) || (op == vrc_pkg::OP_SDIV)
         || (op == vrc_pkg::OP_PDIV);
    cnt_next = (multi && !last) ? cnt + 1'b1 : '0;
  end

  // square root and step count trial values
  assign rcat = {rrem, rv[2*RW-1 -: 2]};
  assign rtry = {root, 2'b01};
  assign ncat = {nrem, root[RW-1]};

  // cell index from the divider lanes
  assign idx    = {dq[2][GRID_Z_BITS-1:0], dq[1][GRID_Y_BITS-1:0], dq[0][GRID_X_BITS-1:0]};
  assign ok_all = dok[0] && dok[1] && dok[2];
  assign den_src = (op == vrc_pkg::OP_PDIV) ? {{(vrc_pkg::DEN_W-10){1'b0}}, vox_eff} : den;
  assign cnt_up  = ok_all && (rdata == vrc_pkg::MARK_UNKNOWN);

  // memory write selection
  always_comb begin
    mem_we = 1'b0;
    waddr  = idx;
    wdata  = vrc_pkg::MARK_UNKNOWN;
    case (op)
      vrc_pkg::OP_CLR: begin
        mem_we = 1'b1;
        waddr  = clr_cnt;
      end
      vrc_pkg::OP_MFREE, vrc_pkg::OP_SFREE: begin
        mem_we = cnt_up;
        wdata  = vrc_pkg::MARK_FREE;
      end
      vrc_pkg::OP_MOCC: begin
        mem_we = ok_all;
        wdata  = vrc_pkg::MARK_OCC;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // grid memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[idx];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      phase    <= '0;
      mcount   <= '0;
      m_tvalid <= 1'b0;
      cnt      <= '0;
      clr_cnt  <= '0;
    end else begin
      cnt     <= cnt_next;
      clr_cnt <= (op == vrc_pkg::OP_CLR) ? clr_cnt + 1'b1 : '0;
      if (op == vrc_pkg::OP_EMIT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (op)
        vrc_pkg::OP_BEGIN: begin
          active <= cast;
          if (cfg.track) phase <= cast ? 8'd0 : phase_inc;
        end
        vrc_pkg::OP_END: begin
          active <= 1'b0;
        end
        vrc_pkg::OP_CLR: begin
          mcount <= '0;
        end
        vrc_pkg::OP_MFREE, vrc_pkg::OP_SFREE, vrc_pkg::OP_MOCC: begin
          if (cnt_up) mcount <= mcount + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (op)
      vrc_pkg::OP_TAKE: begin
        pt[0]       <= in_data[15:0];
        pt[1]       <= in_data[31:16];
        pt[2]       <= in_data[47:32];
        res_class   <= vrc_pkg::CLASS_NONE;
        res_taken   <= 1'b0;
        res_cleared <= 1'b0;
      end
      vrc_pkg::OP_BEGIN: begin
        sen[0]    <= pt[0];
        sen[1]    <= pt[1];
        sen[2]    <= pt[2];
        res_taken <= cast;
      end
      vrc_pkg::OP_END: begin
        res_cleared <= over;
      end
      vrc_pkg::OP_SQ: begin
        if (cnt == 5'd1) begin
          sum <= prod[vrc_pkg::SUM_W-1:0];
        end else if (cnt != 5'd0) begin
          sum <= sum + prod[vrc_pkg::SUM_W-1:0];
        end
      end
      vrc_pkg::OP_ROOT: begin
        if (cnt == 5'd0) begin
          rv   <= {sum, 2'b00};
          rrem <= '0;
          root <= '0;
        end else begin
          rv <= {rv[2*RW-3:0], 2'b00};
          if (rcat >= {2'b00, rtry}) begin
            rrem <= (RW+2)'(rcat - {2'b00, rtry});
            root <= {root[RW-2:0], 1'b1};
          end else begin
            rrem <= rcat[RW+1:0];
            root <= {root[RW-2:0], 1'b0};
          end
        end
      end
      vrc_pkg::OP_NDIV: begin
        if (cnt == 5'd0) begin
          nrem <= '0;
        end else begin
          root <= {root[RW-2:0], 1'b0};
          if (ncat >= {1'b0, step2}) begin
            nrem <= vrc_pkg::STEP2_W'(ncat - {1'b0, step2});
            nq   <= {nq[RW-2:0], 1'b1};
          end else begin
            nrem <= ncat[vrc_pkg::STEP2_W-1:0];
            nq   <= {nq[RW-2:0], 1'b0};
          end
        end
      end
      vrc_pkg::OP_SETUP: begin
        case (cnt)
          5'd0:    steps <= (nq == '0) ? RW'(1) : nq;
          5'd2:    den <= prod[vrc_pkg::DEN_W-1:0];
          5'd3:    nacc[0] <= prod[NUM_W-1:0];
          5'd4:    nacc[1] <= prod[NUM_W-1:0];
          5'd5: begin
            nacc[2] <= prod[NUM_W-1:0];
            s_idx   <= '0;
          end
          default: begin
          end
        endcase
      end
      vrc_pkg::OP_SDIV, vrc_pkg::OP_PDIV: begin
        if (cnt == 5'd0) begin
          dsh <= {{(QB-1){1'b0}}, den_src} << (QB-1);
          for (int k = 0; k < 3; k++) begin
            drem[k] <= lnum[k][NUM_W-2:0];
            dok[k]  <= !lnum[k][NUM_W-1]
                       && (CMP_W'(lnum[k][NUM_W-2:0])
                           < (CMP_W'(den_src) << AB[k]));
          end
        end else begin
          dsh <= dsh >> 1;
          for (int k = 0; k < 3; k++) begin
            if (CMP_W'(drem[k]) >= CMP_W'(dsh)) begin
              drem[k] <= (NUM_W-1)'(CMP_W'(drem[k]) - CMP_W'(dsh));
              dq[k]   <= {dq[k][QB-2:0], 1'b1};
            end else begin
              dq[k]   <= {dq[k][QB-2:0], 1'b0};
            end
          end
        end
      end
      vrc_pkg::OP_SFREE: begin
        for (int k = 0; k < 3; k++) begin
          nacc[k] <= nacc[k] + {{(NUM_W-17){dlt[k][16]}}, dlt[k]};
        end
        s_idx <= s_idx + 1'b1;
      end
      vrc_pkg::OP_QRY: begin
        if (!ok_all)         res_class <= vrc_pkg::CLASS_NONE;
        else if (!cfg.track) res_class <= vrc_pkg::CLASS_OFF;
        else                 res_class <= {1'b0, rdata} + 3'd1;
      end
      vrc_pkg::OP_EMIT: begin
        m_tdata <= {3'b000, res_cleared, res_taken, res_class};
      end
      default: begin
      end
    endcase
  end

  // status to the controller
  always_comb begin
    st.last         = last;
    st.cast         = cast;
    st.acc          = cfg.acc;
    st.active       = active;
    st.over         = over;
    st.samples_done = (({1'b0, s_idx} + 1'b1) == {1'b0, steps});
    st.out_free     = !m_tvalid || m_tready;
  end

endmodule

// ===== rtl/voxel_raycast_observed_space_core.sv =====
// top level of the voxel ray-cast core: register file, controller and datapath
// depends on vrc_pkg, vrc_ctrl, vrc_datapath
//
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  s_tuser command, s_tdata x, y, z
// m_axis    out  m_tvalid/m_tready  m_tdata query_class, cloud_taken, cache_cleared
// cfg       in   cfg_we             cfg_addr register index, cfg_wdata value
//
// one item at a time; an endpoint in a cast cloud runs the cell divider once per ray sample
// and once more for its own cell
// a grid clear sweeps the memory one cell a cycle over all 2^(X+Y+Z bits) cells
// after reset the same sweep runs before the first item is taken
// a stalled output word holds; the next item is still accepted while it waits
module voxel_raycast_observed_space_core #(
  parameter int GRID_X_BITS = 7,
  parameter int GRID_Y_BITS = 7,
  parameter int GRID_Z_BITS = 5,
  parameter int MARK_LIMIT  = 262144
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // x_mm, y_mm, z_mm
  input  logic [1:0]  s_tuser,   // command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // query_class, cloud_taken, cache_cleared, zero pad
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  vrc_pkg::cfg_t    cfg;
  vrc_pkg::status_t st;
  vrc_pkg::op_t     op;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ox        <= -16'sd3200;
      cfg.oy        <= -16'sd3200;
      cfg.oz        <= -16'sd800;
      cfg.voxel     <= 10'd50;
      cfg.samp_step <= 14'd100;
      cfg.decim     <= 8'd4;
      cfg.track     <= 1'b1;
      cfg.acc       <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_addr)
        vrc_pkg::CFG_ORIGIN_X: cfg.ox        <= cfg_wdata;
        vrc_pkg::CFG_ORIGIN_Y: cfg.oy        <= cfg_wdata;
        vrc_pkg::CFG_ORIGIN_Z: cfg.oz        <= cfg_wdata;
        vrc_pkg::CFG_VOXEL:    cfg.voxel     <= cfg_wdata[9:0];
        vrc_pkg::CFG_STEP:     cfg.samp_step <= cfg_wdata[13:0];
        vrc_pkg::CFG_DECIM:    cfg.decim     <= cfg_wdata[7:0];
        vrc_pkg::CFG_TRACK:    cfg.track     <= cfg_wdata[0];
        vrc_pkg::CFG_ACCUM:    cfg.acc       <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  vrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .st       (st),
    .op       (op)
  );

  vrc_datapath #(
    .GRID_X_BITS (GRID_X_BITS),
    .GRID_Y_BITS (GRID_Y_BITS),
    .GRID_Z_BITS (GRID_Z_BITS),
    .MARK_LIMIT  (MARK_LIMIT)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .op       (op),
    .in_data  (s_tdata),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== rtl/vrc_checker.sv =====
// port-level checks of the voxel ray-cast core, bound to the top level
// depends on voxel_raycast_observed_space_core_macros.svh
`include "voxel_raycast_observed_space_core_macros.svh"

module vrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // stalled word stays offered
  `VRC_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "output word dropped")

  // one item in flight: ready drops right after an accept
  `VRC_ASSERT_NXT(a_one_item, clk, rst, s_tvalid && s_tready, !s_tready, "second item taken")

  // clearing sweep after reset holds off input
  `VRC_ASSERT_IMP(a_init_busy, clk, rst, $past(rst), !s_tready, "input taken during sweep")

  // a word answers only one kind of item
  `VRC_ASSERT_IMP(a_one_kind, clk, rst, m_tvalid,
                  (m_tdata[2:0] == 3'd0) || (!m_tdata[3] && !m_tdata[4]),
                  "query class mixed with cloud flags")

endmodule

bind voxel_raycast_observed_space_core vrc_checker u_vrc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/tb_voxel_raycast_observed_space_core.sv =====
// self-checking testbench for voxel_raycast_observed_space_core
// depends on vrc_pkg and the core; an in-bench grid predictor checks every result word
`timescale 1ns / 1ps

module tb_voxel_raycast_observed_space_core;

  localparam int XB = 7;
  localparam int YB = 7;
  localparam int ZB = 5;
  localparam int CELLS = 1 << (XB + YB + ZB);
  localparam int LIMIT_MARKS = 262144;
  localparam int QUIET_LIMIT = 2000000;
  localparam int SETTLE = 200;

  typedef struct packed {
    logic [2:0] cls;
    logic       taken;
    logic       cleared;
  } result_t;

  // grid predictor plus store of pending result words
  class grid_scoreboard;
    longint ox, oy, oz;
    int unsigned voxel, rstep, decim, track, accum;
    logic [1:0] marks [CELLS];
    int unsigned marked, phase;
    bit active;
    longint sx, sy, sz;
    result_t pending[$];
    int errors, words, casts, rays, clears;
    int class_seen [5];

    function new();
      ox = -3200; oy = -3200; oz = -800;
      voxel = 50; rstep = 100; decim = 4; track = 1; accum = 1;
      wipe();
      phase = 0; active = 0; sx = 0; sy = 0; sz = 0;
    endfunction

    function void wipe();
      for (int i = 0; i < CELLS; i++) marks[i] = vrc_pkg::MARK_UNKNOWN;
      marked = 0;
    endfunction

    function int unsigned vox_eff();
      return (voxel == 0) ? 1 : voxel;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        vrc_pkg::CFG_ORIGIN_X: ox = longint'($signed(val));
        vrc_pkg::CFG_ORIGIN_Y: oy = longint'($signed(val));
        vrc_pkg::CFG_ORIGIN_Z: oz = longint'($signed(val));
        vrc_pkg::CFG_VOXEL:    voxel = val[9:0];
        vrc_pkg::CFG_STEP:     rstep = val[13:0];
        vrc_pkg::CFG_DECIM:    decim = val[7:0];
        vrc_pkg::CFG_TRACK:    track = val[0];
        vrc_pkg::CFG_ACCUM:    accum = val[0];
        default: ;
      endcase
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // cell index of (nx, ny, nz) / den, or -1 when outside
    function int cell_at(longint nx, longint ny, longint nz, longint den);
      longint qx, qy, qz;
      if (nx < 0 || ny < 0 || nz < 0) return -1;
      qx = nx / den; qy = ny / den; qz = nz / den;
      if (qx >= (1 << XB) || qy >= (1 << YB) || qz >= (1 << ZB)) return -1;
      return int'((qz << (XB + YB)) | (qy << XB) | qx);
    endfunction

    function int point_cell(longint x, longint y, longint z);
      return cell_at(x - ox, y - oy, z - oz, longint'(vox_eff()));
    endfunction

    function void mark_free(int idx);
      if (marks[idx] == vrc_pkg::MARK_UNKNOWN) begin
        marks[idx] = vrc_pkg::MARK_FREE;
        marked++;
      end
    endfunction

    function void walk_ray(longint px, longint py, longint pz);
      longint dx, dy, dz, steps, den, bx, by, bz;
      longint unsigned len2, step2;
      int idx;
      dx = px - sx; dy = py - sy; dz = pz - sz;
      len2 = root(4 * longint'(dx * dx + dy * dy + dz * dz));
      step2 = 2 * rstep;
      if (step2 < vox_eff()) step2 = vox_eff();
      steps = longint'(len2 / step2);
      if (steps == 0) steps = 1;
      den = steps * vox_eff();
      bx = (sx - ox) * steps; by = (sy - oy) * steps; bz = (sz - oz) * steps;
      for (longint s = 0; s < steps; s++) begin
        idx = cell_at(bx + s * dx, by + s * dy, bz + s * dz, den);
        if (idx >= 0) mark_free(idx);
      end
      idx = point_cell(px, py, pz);
      if (idx >= 0) begin
        if (marks[idx] == vrc_pkg::MARK_UNKNOWN) marked++;
        marks[idx] = vrc_pkg::MARK_OCC;
      end
      rays++;
    endfunction

    // accepted input word: update the grid and queue the expected result
    function void note_word(logic [1:0] cmd, logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
      result_t r;
      int idx;
      int unsigned dec;
      r = '0;
      case (cmd)
        vrc_pkg::CMD_BEGIN: begin
          dec = (decim == 0) ? 1 : decim;
          sx = x; sy = y; sz = z;
          active = 0;
          if (track != 0) begin
            phase = (phase + 1) & 8'hFF;
            if (phase >= dec) begin
              phase = 0;
              active = 1;
              if (accum == 0) wipe();
              idx = point_cell(x, y, z);
              if (idx >= 0) mark_free(idx);
              r.taken = 1;
              casts++;
            end
          end
        end
        vrc_pkg::CMD_POINT: if (active) walk_ray(x, y, z);
        vrc_pkg::CMD_END: begin
          if (active && marked > LIMIT_MARKS) begin
            wipe();
            r.cleared = 1;
            clears++;
          end
          active = 0;
        end
        default: begin
          idx = point_cell(x, y, z);
          if (idx < 0) r.cls = vrc_pkg::CLASS_NONE;
          else if (track == 0) r.cls = vrc_pkg::CLASS_OFF;
          else r.cls = {1'b0, marks[idx]} + 3'd1;
          class_seen[r.cls]++;
        end
      endcase
      pending = {pending, r};
    endfunction

    function void check_word(logic [7:0] data);
      result_t got, want;
      got.cls = data[2:0];
      got.taken = data[3];
      got.cleared = data[4];
      words++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, data);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.cls !== want.cls) begin
        $display("%0t: query_class expected %0d actual %0d", $time, want.cls, got.cls);
        errors++;
      end
      if (got.taken !== want.taken) begin
        $display("%0t: cloud_taken expected %0d actual %0d", $time, want.taken, got.taken);
        errors++;
      end
      if (got.cleared !== want.cleared) begin
        $display("%0t: cache_cleared expected %0d actual %0d", $time, want.cleared,
                 got.cleared);
        errors++;
      end
      if (data[7:5] !== 3'b000) begin
        $display("%0t: pad bits expected 0 actual %b", $time, data[7:5]);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [47:0] s_tdata;   // x_mm, y_mm, z_mm
  logic [1:0]  s_tuser;   // command
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // query_class, cloud_taken, cache_cleared, zero pad
  logic        cfg_we;
  logic [2:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  grid_scoreboard sb;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_req;
  int quiet;
  int sent;

  voxel_raycast_observed_space_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // 10 ns clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // receiver: random stalls plus a long hold-off when requested
  always @(negedge clk) begin
    int hold_cnt;
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
    else quiet++;
    if (quiet > QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d words pending", $time, quiet,
               sb.pending.size());
      $display("tb_voxel_raycast_observed_space_core failed");
      $finish;
    end
  end

  // one input word; valid stays high straight into the next word unless a gap is drawn
  task automatic send_word(logic [1:0] cmd, logic [15:0] x, logic [15:0] y, logic [15:0] z);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {z, y, x};
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_word(cmd, x, y, z);
    sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic set_geometry(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz,
                              logic [15:0] vox, logic [15:0] stp, logic [15:0] dec);
    write_reg(vrc_pkg::CFG_ORIGIN_X, ox);
    write_reg(vrc_pkg::CFG_ORIGIN_Y, oy);
    write_reg(vrc_pkg::CFG_ORIGIN_Z, oz);
    write_reg(vrc_pkg::CFG_VOXEL, vox);
    write_reg(vrc_pkg::CFG_STEP, stp);
    write_reg(vrc_pkg::CFG_DECIM, dec);
  endtask

  // coordinate near the grid along one axis; full-range noise only when rays stay short
  function automatic logic [15:0] pick_coord(longint org, int bits);
    longint span, lo, hi, stp;
    stp = 2 * sb.rstep;
    if (stp < sb.vox_eff()) stp = sb.vox_eff();
    if (stp >= 100 && $urandom_range(7) == 0) return 16'($urandom);
    span = longint'(sb.vox_eff()) << bits;
    lo = org - 2 * sb.vox_eff();
    hi = org + span + 2 * sb.vox_eff();
    if (lo < -32768) lo = -32768;
    if (hi > 32767) hi = 32767;
    if (lo > hi) lo = hi;
    return 16'(lo + longint'($urandom_range(int'(hi - lo))));
  endfunction

  task automatic send_at(logic [1:0] cmd);
    send_word(cmd, pick_coord(sb.ox, XB), pick_coord(sb.oy, YB), pick_coord(sb.oz, ZB));
  endtask

  // mostly well-formed clouds with queries mixed in, some broken or stray words
  task automatic run_clouds(int n);
    int goal;
    int npts;
    goal = sent + n;
    while (sent < goal) begin
      if ($urandom_range(9) == 0) begin
        send_at(2'($urandom_range(3)));
      end else begin
        send_at(vrc_pkg::CMD_BEGIN);
        npts = $urandom_range(1, 8);
        for (int i = 0; i < npts; i++) begin
          send_at(vrc_pkg::CMD_POINT);
          if ($urandom_range(3) == 0) send_at(vrc_pkg::CMD_QUERY);
        end
        if ($urandom_range(9) != 0) send_at(vrc_pkg::CMD_END);
        for (int i = $urandom_range(3); i > 0; i--) send_at(vrc_pkg::CMD_QUERY);
      end
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = vrc_pkg::CMD_BEGIN;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = vrc_pkg::CFG_ORIGIN_X;
    cfg_wdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    quiet = 0;
    sent = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed: reset settings, decimation of four, rays to corners and far outside
    send_word(vrc_pkg::CMD_POINT, 16'd100, 16'd0, 16'd0);
    send_word(vrc_pkg::CMD_END, 16'd0, 16'd0, 16'd0);
    for (int i = 0; i < 3; i++) send_word(vrc_pkg::CMD_BEGIN, 16'd0, 16'd0, 16'd0);
    send_word(vrc_pkg::CMD_BEGIN, 16'd0, 16'd0, 16'd0);
    send_word(vrc_pkg::CMD_POINT, 16'd1000, 16'd0, 16'd0);
    send_word(vrc_pkg::CMD_POINT, -16'sd3200, -16'sd3200, -16'sd800);
    send_word(vrc_pkg::CMD_POINT, 16'd3199, 16'd3199, 16'd799);
    send_word(vrc_pkg::CMD_POINT, 16'd0, 16'd0, 16'd0);
    send_word(vrc_pkg::CMD_POINT, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_word(vrc_pkg::CMD_POINT, 16'h8000, 16'h8000, 16'h8000);
    send_word(vrc_pkg::CMD_QUERY, 16'd0, 16'd0, 16'd0);
    send_word(vrc_pkg::CMD_QUERY, 16'd1000, 16'd0, 16'd0);
    send_word(vrc_pkg::CMD_QUERY, 16'd500, 16'd0, 16'd0);
    send_word(vrc_pkg::CMD_QUERY, 16'd0, 16'd3000, 16'd0);
    send_word(vrc_pkg::CMD_QUERY, 16'd3200, 16'd0, 16'd0);
    send_word(vrc_pkg::CMD_QUERY, 16'h8000, 16'h7FFF, 16'h8000);
    for (int i = 0; i < 3; i++) send_word(vrc_pkg::CMD_BEGIN, 16'd50, 16'd50, 16'd0);
    send_word(vrc_pkg::CMD_BEGIN, 16'd50, 16'd50, 16'd0);
    send_word(vrc_pkg::CMD_END, 16'd0, 16'd0, 16'd0);
    send_word(vrc_pkg::CMD_END, 16'd0, 16'd0, 16'd0);
    drain();

    // reset geometry, no idling
    write_reg(vrc_pkg::CFG_DECIM, 16'd2);
    run_clouds(140);
    drain();

    // coarse voxels, step floored at half a voxel; sender idles, receiver holds off
    set_geometry(-16'sd6400, -16'sd6400, -16'sd1600, 16'd100, 16'd50, 16'd1);
    send_idle_pct = 74;
    hold_req = 1;
    run_clouds(140);
    drain();

    // fine voxels, long step; receiver stalls
    set_geometry(16'd0, 16'd0, 16'd0, 16'd20, 16'd10000, 16'd3);
    send_idle_pct = 0;
    recv_stall_pct = 74;
    run_clouds(140);
    drain();

    // voxel of 1000, lowest origin; both sides idle
    set_geometry(16'h8000, 16'h8000, 16'h8000, 16'd1000, 16'd1, 16'd1);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    run_clouds(110);
    drain();

    // zero voxel, zero step, zero decimation; one cloud that clears the grid first
    set_geometry(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_reg(vrc_pkg::CFG_ACCUM, 16'd0);
    send_word(vrc_pkg::CMD_BEGIN, 16'd10, 16'd10, 16'd5);
    send_word(vrc_pkg::CMD_POINT, 16'd60, 16'd20, 16'd10);
    send_word(vrc_pkg::CMD_QUERY, 16'd60, 16'd20, 16'd10);
    send_word(vrc_pkg::CMD_END, 16'd0, 16'd0, 16'd0);
    drain();
    write_reg(vrc_pkg::CFG_ACCUM, 16'd1);
    run_clouds(80);
    drain();

    // tracking off, highest origin
    write_reg(vrc_pkg::CFG_TRACK, 16'd0);
    set_geometry(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd1, 16'd16383, 16'd255);
    recv_stall_pct = 74;
    run_clouds(30);
    drain();
    set_geometry(-16'sd3200, -16'sd3200, -16'sd800, 16'd50, 16'd100, 16'd255);
    run_clouds(30);
    drain();

    // tracking back on, decimation at its top
    write_reg(vrc_pkg::CFG_TRACK, 16'd1);
    recv_stall_pct = 0;
    run_clouds(40);
    drain();

    $display("%0d words sent, %0d results, %0d clouds cast, %0d rays, %0d grid clears",
             sent, sb.words, sb.casts, sb.rays, sb.clears);
    $display("queries: %0d outside, %0d unknown, %0d free, %0d occupied, %0d tracking off",
             sb.class_seen[0], sb.class_seen[1], sb.class_seen[2], sb.class_seen[3],
             sb.class_seen[4]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_voxel_raycast_observed_space_core passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("tb_voxel_raycast_observed_space_core failed");
    end
    $finish;
  end

endmodule
